### rtl/assert_macros.svh
// concurrent assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sps assertion failed");
`define SPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sps implication failed");
`else
`define SPS_ASSERT(lbl, clk, rstn, prop)
`define SPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/sps_pkg.sv
// types, codes and constants of the sweep point sequencer
package sps_pkg;

    localparam int POINT_W   = 13;
    localparam int TIMEOUT_W = 19;
    localparam int POWER_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 19;

    localparam logic [POINT_W-1:0]   MAX_POINTS    = 13'd4096;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 19'd500000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POINT_TOTAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIMEOUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMIT_ENABLED  = 2'd3;

    // commands
    localparam logic [1:0] FUNC_POLL  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    // controller states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_PREPARE   = 4'd1;
    localparam logic [3:0] ST_SETLO     = 4'd2;
    localparam logic [3:0] ST_WAITLOCK  = 4'd3;
    localparam logic [3:0] ST_ARM       = 4'd4;
    localparam logic [3:0] ST_REARM     = 4'd5;
    localparam logic [3:0] ST_WAITFRAME = 4'd6;
    localparam logic [3:0] ST_MEASURE   = 4'd7;
    localparam logic [3:0] ST_EMIT      = 4'd8;
    localparam logic [3:0] ST_NEXT      = 4'd9;
    localparam logic [3:0] ST_DONE      = 4'd10;
    localparam logic [3:0] ST_ABORTED   = 4'd11;
    localparam logic [3:0] ST_ERROR     = 4'd12;

    // status codes
    localparam logic [2:0] E_OK    = 3'd0;
    localparam logic [2:0] E_PLAN  = 3'd1;
    localparam logic [2:0] E_LOSET = 3'd2;
    localparam logic [2:0] E_LOCK  = 3'd3;
    localparam logic [2:0] E_FRAME = 3'd4;
    localparam logic [2:0] E_MEAS  = 3'd5;
    localparam logic [2:0] E_CONS  = 3'd6;

    // action requests
    localparam logic [3:0] ACT_NONE    = 4'd0;
    localparam logic [3:0] ACT_DSP     = 4'd1;
    localparam logic [3:0] ACT_SETLO   = 4'd2;
    localparam logic [3:0] ACT_DMA     = 4'd3;
    localparam logic [3:0] ACT_REDMA   = 4'd4;
    localparam logic [3:0] ACT_ACCUM   = 4'd5;
    localparam logic [3:0] ACT_MEASURE = 4'd6;
    localparam logic [3:0] ACT_EMIT    = 4'd7;
    localparam logic [3:0] ACT_RSTACC  = 4'd8;

    typedef struct packed {
        logic [1:0]                func;
        logic                      plan_ok;
        logic                      lo_set_ok;
        logic                      lo_locked;
        logic                      dma_reset_ok;
        logic                      dma_start_ok;
        logic                      dma_error;
        logic                      frame_ready;
        logic                      accum_done;
        logic                      measure_ok;
        logic signed [POWER_W-1:0] power_in;
        logic                      consumer_ok;
    } cmd_t;

    typedef struct packed {
        logic [3:0]                ctrl_state;
        logic [2:0]                status;
        logic [3:0]                action;
        logic [POINT_W-1:0]        point_index;
        logic signed [POWER_W-1:0] power_out;
        logic                      last_point;
        logic                      active;
    } rsp_t;

    typedef struct packed {
        logic [POINT_W-1:0]   point_total;
        logic [TIMEOUT_W-1:0] lock_timeout;
        logic [TIMEOUT_W-1:0] frame_timeout;
        logic                 emit_enabled;
    } cfg_t;

endpackage

### rtl/sps_if.sv
// valid/ready channel interfaces for commands and results
interface sps_cmd_if import sps_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [1:0]                func;
    logic                      plan_ok;
    logic                      lo_set_ok;
    logic                      lo_locked;
    logic                      dma_reset_ok;
    logic                      dma_start_ok;
    logic                      dma_error;
    logic                      frame_ready;
    logic                      accum_done;
    logic                      measure_ok;
    logic signed [POWER_W-1:0] power_in;
    logic                      consumer_ok;

    modport source (
        output valid, func, plan_ok, lo_set_ok, lo_locked, dma_reset_ok, dma_start_ok,
               dma_error, frame_ready, accum_done, measure_ok, power_in, consumer_ok,
        input  ready
    );
    modport sink (
        input  valid, func, plan_ok, lo_set_ok, lo_locked, dma_reset_ok, dma_start_ok,
               dma_error, frame_ready, accum_done, measure_ok, power_in, consumer_ok,
        output ready
    );
endinterface

interface sps_rsp_if import sps_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [3:0]                ctrl_state;
    logic [2:0]                status;
    logic [3:0]                action;
    logic [POINT_W-1:0]        point_index;
    logic signed [POWER_W-1:0] power_out;
    logic                      last_point;
    logic                      active;

    modport source (
        output valid, ctrl_state, status, action, point_index, power_out, last_point,
               active,
        input  ready
    );
    modport sink (
        input  valid, ctrl_state, status, action, point_index, power_out, last_point,
               active,
        output ready
    );
endinterface

### rtl/sweep_point_sequencer.sv
// top level of the sweep point sequencer: channels, config registers and pipeline
//
// usage
//   cmd: one transfer per command (poll, start, stop) with the outcomes of the
//     external steps that the current state asked for
//   rsp: exactly one result transfer per command, in order: new state, status,
//     requested action, point index, held power, last-point and active flags
//   cfg: write cfg_we with cfg_index and cfg_data; only while no command is in
//     flight. index 0 point total, 1 lock timeout, 2 frame timeout, 3 emit enable
// timing
//   a command taken is held in the input register; once the result register is free or
//   draining, the controller update loads the result register, from which the result
//   transfers; throughput is one command per cycle while rsp.ready stays high, and
//   the controller updates its state on each advance
// reset
//   rst_n clears the controller to idle with zero counters, power and error,
//   timeouts return to 500000, point total and emit enable to zero
// stall
//   while rsp.ready is low the result register holds, the input register still
//   takes one more command, and cmd.ready drops once both are full
`include "assert_macros.svh"
module sweep_point_sequencer
    import sps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sps_cmd_if.sink               cmd,
    sps_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    cmd_t in_reg;
    logic in_valid_reg;
    rsp_t out_reg;
    logic out_valid_reg;

    cmd_t cmd_item;
    rsp_t core_res;
    logic advance;

    // pack the incoming channel fields
    always_comb
    begin
        cmd_item.func         = cmd.func;
        cmd_item.plan_ok      = cmd.plan_ok;
        cmd_item.lo_set_ok    = cmd.lo_set_ok;
        cmd_item.lo_locked    = cmd.lo_locked;
        cmd_item.dma_reset_ok = cmd.dma_reset_ok;
        cmd_item.dma_start_ok = cmd.dma_start_ok;
        cmd_item.dma_error    = cmd.dma_error;
        cmd_item.frame_ready  = cmd.frame_ready;
        cmd_item.accum_done   = cmd.accum_done;
        cmd_item.measure_ok   = cmd.measure_ok;
        cmd_item.power_in     = cmd.power_in;
        cmd_item.consumer_ok  = cmd.consumer_ok;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.point_total   <= '0;
            cfg_reg.lock_timeout  <= TIMEOUT_RESET;
            cfg_reg.frame_timeout <= TIMEOUT_RESET;
            cfg_reg.emit_enabled  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POINT_TOTAL:   cfg_reg.point_total   <= cfg_data[POINT_W-1:0];
                REG_LOCK_TIMEOUT:  cfg_reg.lock_timeout  <= cfg_data[TIMEOUT_W-1:0];
                REG_FRAME_TIMEOUT: cfg_reg.frame_timeout <= cfg_data[TIMEOUT_W-1:0];
                REG_EMIT_ENABLED:  cfg_reg.emit_enabled  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // the held command moves on when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.valid && cmd.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_reg <= cmd_item;
        end
    end

    // controller, updates its state on each advance
    sps_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_reg),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= core_res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ctrl_state  = out_reg.ctrl_state;
    assign rsp.status      = out_reg.status;
    assign rsp.action      = out_reg.action;
    assign rsp.point_index = out_reg.point_index;
    assign rsp.power_out   = out_reg.power_out;
    assign rsp.last_point  = out_reg.last_point;
    assign rsp.active      = out_reg.active;

    // every advance leaves a result waiting in the result register
    `SPS_ASSERT(a_advance_fills_out, clk, rst_n, advance |=> out_valid_reg)

endmodule

### rtl/sps_core.sv
// sweep controller state and its combinational update for one command
`include "assert_macros.svh"
module sps_core
    import sps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  cmd_t item,
    input  cfg_t cfg,
    output rsp_t res
);

    logic [3:0]                state_reg, state_next;
    logic [POINT_W-1:0]        pc_reg, pc_next;
    logic [TIMEOUT_W-1:0]      wc_reg, wc_next;
    logic                      sp_reg, sp_next;
    logic signed [POWER_W-1:0] hp_reg, hp_next;
    logic [2:0]                le_reg, le_next;

    logic [2:0]           status;
    logic [3:0]           action;
    logic                 last;
    logic                 active_now;
    logic [POINT_W-1:0]   eff_total;
    logic [POINT_W-1:0]   pc_inc;
    logic [TIMEOUT_W-1:0] wc_inc;
    logic [POINT_W:0]     pc_plus;

    assign active_now = (state_reg >= ST_PREPARE) && (state_reg <= ST_NEXT);
    assign eff_total  = (cfg.point_total > MAX_POINTS) ? MAX_POINTS : cfg.point_total;
    assign pc_inc     = pc_reg + 1'b1;
    assign wc_inc     = wc_reg + 1'b1;
    assign pc_plus    = {1'b0, pc_reg} + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        wc_next    = wc_reg;
        sp_next    = sp_reg;
        hp_next    = hp_reg;
        le_next    = le_reg;
        status     = E_OK;
        action     = ACT_NONE;
        last       = 1'b0;
        unique case (item.func)
            FUNC_START:
            begin
                if (active_now)
                begin
                    sp_next = 1'b1;
                end
                if (!item.plan_ok)
                begin
                    status = E_PLAN;
                end
                else
                begin
                    pc_next    = '0;
                    wc_next    = '0;
                    hp_next    = '0;
                    sp_next    = 1'b0;
                    le_next    = E_OK;
                    state_next = ST_PREPARE;
                end
            end
            FUNC_STOP:
            begin
                if (active_now)
                begin
                    sp_next = 1'b1;
                end
            end
            FUNC_POLL:
            begin
                if (sp_reg && active_now)
                begin
                    state_next = ST_ABORTED;
                    sp_next    = 1'b0;
                end
                else
                begin
                    unique case (state_reg) inside
                        ST_IDLE, ST_DONE, ST_ABORTED:
                        begin
                        end
                        ST_PREPARE:
                        begin
                            action     = ACT_DSP;
                            pc_next    = '0;
                            state_next = ST_SETLO;
                        end
                        ST_SETLO:
                        begin
                            if (pc_reg >= eff_total)
                            begin
                                state_next = ST_DONE;
                                le_next    = E_OK;
                            end
                            else
                            begin
                                action = ACT_SETLO;
                                if (!item.lo_set_ok)
                                begin
                                    status     = E_LOSET;
                                    le_next    = E_LOSET;
                                    state_next = ST_ERROR;
                                end
                                else
                                begin
                                    wc_next    = '0;
                                    state_next = ST_WAITLOCK;
                                end
                            end
                        end
                        ST_WAITLOCK:
                        begin
                            if (item.lo_locked)
                            begin
                                state_next = ST_ARM;
                            end
                            else
                            begin
                                wc_next = wc_inc;
                                if (wc_inc >= cfg.lock_timeout)
                                begin
                                    status     = E_LOCK;
                                    le_next    = E_LOCK;
                                    state_next = ST_ERROR;
                                end
                            end
                        end
                        ST_ARM:
                        begin
                            action = ACT_DMA;
                            if (!item.dma_reset_ok || !item.dma_start_ok)
                            begin
                                status     = E_FRAME;
                                le_next    = E_FRAME;
                                state_next = ST_ERROR;
                            end
                            else
                            begin
                                wc_next    = '0;
                                state_next = ST_WAITFRAME;
                            end
                        end
                        ST_REARM:
                        begin
                            action = ACT_REDMA;
                            if (!item.dma_start_ok)
                            begin
                                status     = E_FRAME;
                                le_next    = E_FRAME;
                                state_next = ST_ERROR;
                            end
                            else
                            begin
                                wc_next    = '0;
                                state_next = ST_WAITFRAME;
                            end
                        end
                        ST_WAITFRAME:
                        begin
                            if (item.dma_error)
                            begin
                                status     = E_FRAME;
                                le_next    = E_FRAME;
                                state_next = ST_ERROR;
                            end
                            else if (item.frame_ready)
                            begin
                                action     = ACT_ACCUM;
                                state_next = item.accum_done ? ST_MEASURE : ST_REARM;
                            end
                            else
                            begin
                                wc_next = wc_inc;
                                if (wc_inc >= cfg.frame_timeout)
                                begin
                                    status     = E_FRAME;
                                    le_next    = E_FRAME;
                                    state_next = ST_ERROR;
                                end
                            end
                        end
                        ST_MEASURE:
                        begin
                            action = ACT_MEASURE;
                            if (!item.measure_ok)
                            begin
                                status     = E_MEAS;
                                le_next    = E_MEAS;
                                state_next = ST_ERROR;
                            end
                            else
                            begin
                                hp_next    = item.power_in;
                                state_next = ST_EMIT;
                            end
                        end
                        ST_EMIT:
                        begin
                            state_next = ST_NEXT;
                            if (cfg.emit_enabled)
                            begin
                                action = ACT_EMIT;
                                last   = (pc_plus >= {1'b0, eff_total});
                                if (!item.consumer_ok)
                                begin
                                    status     = E_CONS;
                                    le_next    = E_CONS;
                                    state_next = ST_ERROR;
                                end
                            end
                        end
                        ST_NEXT:
                        begin
                            pc_next = pc_inc;
                            if (pc_inc >= eff_total)
                            begin
                                state_next = ST_DONE;
                                le_next    = E_OK;
                            end
                            else
                            begin
                                action     = ACT_RSTACC;
                                state_next = ST_SETLO;
                            end
                        end
                        default:
                        begin
                            // error state and unused codes report the held error
                            status = le_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                // unused command, nothing changes
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            wc_reg    <= '0;
            sp_reg    <= 1'b0;
            hp_reg    <= '0;
            le_reg    <= E_OK;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            wc_reg    <= wc_next;
            sp_reg    <= sp_next;
            hp_reg    <= hp_next;
            le_reg    <= le_next;
        end
    end

    always_comb
    begin
        res.ctrl_state  = state_next;
        res.status      = status;
        res.action      = action;
        res.point_index = pc_next;
        res.power_out   = hp_next;
        res.last_point  = last;
        res.active      = (state_next >= ST_PREPARE) && (state_next <= ST_NEXT);
    end

    // a pending stop only lives while a sweep is running
    `SPS_ASSERT_IMPL(a_stop_only_active, clk, rst_n, sp_reg, active_now)
    // the error state holds under polls
    `SPS_ASSERT(a_error_sticky, clk, rst_n,
        (fire && item.func == FUNC_POLL && state_reg == ST_ERROR) |=> (state_reg == ST_ERROR))

endmodule

### tb/sv/testbench.sv
// self-checking testbench of the sweep point sequencer: stimulus, prediction and checks
`timescale 1ns / 1ps
module testbench;
    import sps_pkg::*;

    // the unused command code; the block must leave everything as it is
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // cycles with no transfer on either channel before the run is declared hung
    localparam int QUIET_LIMIT = 2000;
    // cycles to linger after the last result, well over the block's latency
    localparam int DRAIN_CYCLES = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sps_cmd_if cmd_ch ();
    sps_rsp_if rsp_ch ();

    sweep_point_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // commands waiting to be offered, and the results they must produce, in order
    cmd_t cmd_backlog[$];
    rsp_t predicted_results[$];
    // the command currently driven on the channel
    cmd_t offered;

    // idle chances in percent, changed per phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    // shadow of the configuration registers
    logic [POINT_W-1:0]   plan_total;
    logic [TIMEOUT_W-1:0] lock_limit;
    logic [TIMEOUT_W-1:0] frame_limit;
    logic                 emit_on;

    // shadow of the controller
    logic [3:0]           seq_state;
    logic [POINT_W-1:0]   seq_point;
    logic [TIMEOUT_W-1:0] seq_wait;
    logic                 seq_stop;
    logic [POWER_W-1:0]   seq_power;
    logic [2:0]           seq_err;

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // prepare through next-point
    function automatic logic in_sweep();
        return seq_state >= ST_PREPARE && seq_state <= ST_NEXT;
    endfunction

    // point total is clamped to the plan capacity
    function automatic int swept_points();
        return (plan_total > MAX_POINTS) ? int'(MAX_POINTS) : int'(plan_total);
    endfunction

    function automatic logic [2:0] enter_error(logic [2:0] code);
        seq_err = code;
        seq_state = ST_ERROR;
        return code;
    endfunction

    // one command through the controller shadow; returns the result it must give
    function automatic rsp_t advance_sequencer(cmd_t c);
        rsp_t r;
        logic [2:0] status;
        logic [3:0] act;
        logic last;
        logic busy;
        status = E_OK;
        act = ACT_NONE;
        last = 1'b0;
        busy = in_sweep();
        case (c.func)
            FUNC_START:
            begin
                // a start during a sweep leaves a stop behind if the plan fails
                if (busy)
                    seq_stop = 1'b1;
                if (!c.plan_ok)
                    status = E_PLAN;
                else
                begin
                    seq_point = '0;
                    seq_wait = '0;
                    seq_power = '0;
                    seq_stop = 1'b0;
                    seq_err = E_OK;
                    seq_state = ST_PREPARE;
                end
            end
            FUNC_STOP:
            begin
                if (busy)
                    seq_stop = 1'b1;
            end
            FUNC_POLL:
            begin
                if (seq_stop && busy)
                begin
                    seq_state = ST_ABORTED;
                    seq_stop = 1'b0;
                end
                else
                begin
                    case (seq_state)
                        ST_IDLE, ST_DONE, ST_ABORTED: ;
                        ST_PREPARE:
                        begin
                            act = ACT_DSP;
                            seq_point = '0;
                            seq_state = ST_SETLO;
                        end
                        ST_SETLO:
                        begin
                            if (int'(seq_point) >= swept_points())
                            begin
                                seq_state = ST_DONE;
                                seq_err = E_OK;
                            end
                            else
                            begin
                                act = ACT_SETLO;
                                if (!c.lo_set_ok)
                                    status = enter_error(E_LOSET);
                                else
                                begin
                                    seq_wait = '0;
                                    seq_state = ST_WAITLOCK;
                                end
                            end
                        end
                        ST_WAITLOCK:
                        begin
                            if (c.lo_locked)
                                seq_state = ST_ARM;
                            else
                            begin
                                seq_wait = seq_wait + 1'b1;
                                if (seq_wait >= lock_limit)
                                    status = enter_error(E_LOCK);
                            end
                        end
                        ST_ARM:
                        begin
                            // a failed reset hides the start outcome
                            act = ACT_DMA;
                            if (!c.dma_reset_ok || !c.dma_start_ok)
                                status = enter_error(E_FRAME);
                            else
                            begin
                                seq_wait = '0;
                                seq_state = ST_WAITFRAME;
                            end
                        end
                        ST_REARM:
                        begin
                            act = ACT_REDMA;
                            if (!c.dma_start_ok)
                                status = enter_error(E_FRAME);
                            else
                            begin
                                seq_wait = '0;
                                seq_state = ST_WAITFRAME;
                            end
                        end
                        ST_WAITFRAME:
                        begin
                            if (c.dma_error)
                                status = enter_error(E_FRAME);
                            else if (c.frame_ready)
                            begin
                                act = ACT_ACCUM;
                                seq_state = c.accum_done ? ST_MEASURE : ST_REARM;
                            end
                            else
                            begin
                                seq_wait = seq_wait + 1'b1;
                                if (seq_wait >= frame_limit)
                                    status = enter_error(E_FRAME);
                            end
                        end
                        ST_MEASURE:
                        begin
                            act = ACT_MEASURE;
                            if (!c.measure_ok)
                                status = enter_error(E_MEAS);
                            else
                            begin
                                seq_power = c.power_in;
                                seq_state = ST_EMIT;
                            end
                        end
                        ST_EMIT:
                        begin
                            // without a consumer the point is simply passed over
                            if (emit_on)
                            begin
                                act = ACT_EMIT;
                                last = (int'(seq_point) + 1 >= swept_points());
                                if (!c.consumer_ok)
                                    status = enter_error(E_CONS);
                                else
                                    seq_state = ST_NEXT;
                            end
                            else
                                seq_state = ST_NEXT;
                        end
                        ST_NEXT:
                        begin
                            seq_point = seq_point + 1'b1;
                            if (int'(seq_point) >= swept_points())
                            begin
                                seq_state = ST_DONE;
                                seq_err = E_OK;
                            end
                            else
                            begin
                                act = ACT_RSTACC;
                                seq_state = ST_SETLO;
                            end
                        end
                        // error state repeats the stored code
                        default: status = seq_err;
                    endcase
                end
            end
            default: ;
        endcase
        r.ctrl_state = seq_state;
        r.status = status;
        r.action = act;
        r.point_index = seq_point;
        r.power_out = seq_power;
        r.last_point = last;
        r.active = in_sweep();
        return r;
    endfunction

    // command driver: offers the backlog, predicts at each accepted transfer
    always @(posedge clk or negedge rst_n)
    begin
        cmd_t nxt;
        if (!rst_n)
            cmd_ch.valid <= 1'b0;
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                predicted_results.push_back(advance_sequencer(offered));
            // the channel is free when nothing is offered or the offer was just taken
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (cmd_backlog.size() > 0 && !chance(send_idle_pct))
                begin
                    nxt = cmd_backlog.pop_front();
                    offered <= nxt;
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.func <= nxt.func;
                    cmd_ch.plan_ok <= nxt.plan_ok;
                    cmd_ch.lo_set_ok <= nxt.lo_set_ok;
                    cmd_ch.lo_locked <= nxt.lo_locked;
                    cmd_ch.dma_reset_ok <= nxt.dma_reset_ok;
                    cmd_ch.dma_start_ok <= nxt.dma_start_ok;
                    cmd_ch.dma_error <= nxt.dma_error;
                    cmd_ch.frame_ready <= nxt.frame_ready;
                    cmd_ch.accum_done <= nxt.accum_done;
                    cmd_ch.measure_ok <= nxt.measure_ok;
                    cmd_ch.power_in <= nxt.power_in;
                    cmd_ch.consumer_ok <= nxt.consumer_ok;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor: every result transfer is checked against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (predicted_results.size() == 0)
                    report_error("result transfer with no command outstanding");
                else
                begin
                    want = predicted_results.pop_front();
                    if (rsp_ch.ctrl_state !== want.ctrl_state)
                        report_error($sformatf("ctrl_state %0d, expected %0d",
                            rsp_ch.ctrl_state, want.ctrl_state));
                    if (rsp_ch.status !== want.status)
                        report_error($sformatf("status %0d, expected %0d",
                            rsp_ch.status, want.status));
                    if (rsp_ch.action !== want.action)
                        report_error($sformatf("action %0d, expected %0d",
                            rsp_ch.action, want.action));
                    if (rsp_ch.point_index !== want.point_index)
                        report_error($sformatf("point_index %0d, expected %0d",
                            rsp_ch.point_index, want.point_index));
                    if (rsp_ch.power_out !== want.power_out)
                        report_error($sformatf("power_out %h, expected %h",
                            rsp_ch.power_out, want.power_out));
                    if (rsp_ch.last_point !== want.last_point)
                        report_error($sformatf("last_point %b, expected %b",
                            rsp_ch.last_point, want.last_point));
                    if (rsp_ch.active !== want.active)
                        report_error($sformatf("active %b, expected %b",
                            rsp_ch.active, want.active));
                end
            end
            rsp_ch.ready <= !chance(recv_idle_pct);
        end
    end

    // hang detection: any transfer on either channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // a poll in which every outside step succeeds
    function automatic cmd_t clean_poll();
        cmd_t c;
        c.func = FUNC_POLL;
        c.plan_ok = 1'b1;
        c.lo_set_ok = 1'b1;
        c.lo_locked = 1'b1;
        c.dma_reset_ok = 1'b1;
        c.dma_start_ok = 1'b1;
        c.dma_error = 1'b0;
        c.frame_ready = 1'b1;
        c.accum_done = 1'b1;
        c.measure_ok = 1'b1;
        c.power_in = POWER_W'($urandom);
        c.consumer_ok = 1'b1;
        return c;
    endfunction

    // a poll with outcomes biased so that sweeps mostly progress, with waits and faults
    function automatic cmd_t random_poll();
        cmd_t c;
        c.func = FUNC_POLL;
        c.plan_ok = chance(50);
        c.lo_set_ok = chance(93);
        c.lo_locked = chance(55);
        c.dma_reset_ok = chance(94);
        c.dma_start_ok = chance(93);
        c.dma_error = chance(4);
        c.frame_ready = chance(65);
        c.accum_done = chance(60);
        c.measure_ok = chance(94);
        c.power_in = POWER_W'($urandom);
        c.consumer_ok = chance(93);
        return c;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        // block is idle, so the shadow can change now
        case (idx)
            REG_POINT_TOTAL:   plan_total = val[POINT_W-1:0];
            REG_LOCK_TIMEOUT:  lock_limit = val[TIMEOUT_W-1:0];
            REG_FRAME_TIMEOUT: frame_limit = val[TIMEOUT_W-1:0];
            default:           emit_on = val[0];
        endcase
    endtask

    // writes all four registers back to back, then lets the last write settle
    task automatic apply_setting(int total, int lock_to, int frame_to, int emit,
                                 int send_pct, int recv_pct);
        write_reg(REG_POINT_TOTAL, CFG_DATA_W'(total));
        write_reg(REG_LOCK_TIMEOUT, CFG_DATA_W'(lock_to));
        write_reg(REG_FRAME_TIMEOUT, CFG_DATA_W'(frame_to));
        write_reg(REG_EMIT_ENABLED, CFG_DATA_W'(emit));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // the sender holds off here until every predicted result has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || cmd_ch.valid || predicted_results.size() != 0);
    endtask

    // sweeps that open with a good start and carry on with biased polls and some noise
    task automatic queue_sweeps(int budget);
        int n = 0;
        int k;
        cmd_t c;
        while (n < budget)
        begin
            c = random_poll();
            c.func = FUNC_START;
            c.plan_ok = 1'b1;
            cmd_backlog.push_back(c);
            n++;
            k = $urandom_range(6, 48);
            repeat (k)
            begin
                c = random_poll();
                if (chance(3))
                    c.func = FUNC_STOP;
                else if (chance(5))
                    c.func = FUNC_START;
                else if (chance(3))
                    c.func = FUNC_UNUSED;
                cmd_backlog.push_back(c);
                if (c.func != FUNC_UNUSED)
                    n++;
            end
        end
    endtask

    // directed walk through one point, the abort paths and the special cases
    task automatic queue_directed();
        cmd_t c;
        // unused command with power all ones and every outcome but dma_error set is ignored
        c = clean_poll();
        c.func = FUNC_UNUSED;
        c.power_in = 16'hFFFF;
        cmd_backlog.push_back(c);
        // stop and failed start while idle
        c = clean_poll();
        c.func = FUNC_STOP;
        cmd_backlog.push_back(c);
        c.func = FUNC_START;
        c.plan_ok = 1'b0;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(clean_poll());
        // one full point: start, prepare, set lo, lock, arm, rearm, measure, emit, next
        c = clean_poll();
        c.func = FUNC_START;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(clean_poll());
        cmd_backlog.push_back(clean_poll());
        cmd_backlog.push_back(clean_poll());
        cmd_backlog.push_back(clean_poll());
        c = clean_poll();
        c.accum_done = 1'b0;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(clean_poll());
        cmd_backlog.push_back(clean_poll());
        c = clean_poll();
        c.power_in = 16'h8000;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(clean_poll());
        cmd_backlog.push_back(clean_poll());
        cmd_backlog.push_back(clean_poll());
        // lock timeout of zero expires at the first poll without lock
        c = clean_poll();
        c.func = FUNC_START;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(clean_poll());
        cmd_backlog.push_back(clean_poll());
        c = clean_poll();
        c.lo_locked = 1'b0;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(clean_poll());
        // restart from error, restart while active, then stop and abort
        c = clean_poll();
        c.func = FUNC_START;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(c);
        c.func = FUNC_STOP;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(clean_poll());
        // a failed start during a sweep leaves a pending stop
        c.func = FUNC_START;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(clean_poll());
        c.plan_ok = 1'b0;
        cmd_backlog.push_back(c);
        c = clean_poll();
        c.power_in = 16'h7FFF;
        cmd_backlog.push_back(c);
    endtask

    initial
    begin
        // every input known from time zero
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.func = FUNC_POLL;
        cmd_ch.plan_ok = 1'b0;
        cmd_ch.lo_set_ok = 1'b0;
        cmd_ch.lo_locked = 1'b0;
        cmd_ch.dma_reset_ok = 1'b0;
        cmd_ch.dma_start_ok = 1'b0;
        cmd_ch.dma_error = 1'b0;
        cmd_ch.frame_ready = 1'b0;
        cmd_ch.accum_done = 1'b0;
        cmd_ch.measure_ok = 1'b0;
        cmd_ch.power_in = '0;
        cmd_ch.consumer_ok = 1'b0;
        rsp_ch.ready = 1'b0;
        // register and controller values after reset
        plan_total = '0;
        lock_limit = TIMEOUT_RESET;
        frame_limit = TIMEOUT_RESET;
        emit_on = 1'b0;
        seq_state = ST_IDLE;
        seq_point = '0;
        seq_wait = '0;
        seq_stop = 1'b0;
        seq_power = '0;
        seq_err = E_OK;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: one-point plan, zero lock timeout, consumer attached
        apply_setting(1, 0, 1, 1, 16, 63);
        queue_directed();
        wait_drained();

        // random phases; each boundary holds the sender until all results are back
        apply_setting(3, 4, 3, 1, 16, 63);
        queue_sweeps(140);
        wait_drained();
        // empty plan, no consumer, timeouts of one
        apply_setting(0, 1, 1, 0, 16, 63);
        queue_sweeps(130);
        wait_drained();
        // longest timeouts, waits never expire
        apply_setting(5, 524287, 524287, 1, 63, 16);
        queue_sweeps(140);
        wait_drained();
        // point total above the capacity is clamped
        apply_setting(8191, 6, 2, 1, 63, 16);
        queue_sweeps(140);
        wait_drained();
        // full-size plan, zero timeouts, no consumer, no idling
        apply_setting(4096, 0, 0, 0, 0, 0);
        queue_sweeps(120);
        wait_drained();
        apply_setting($urandom_range(0, 6), $urandom_range(0, 8), $urandom_range(0, 8),
                      $urandom_range(0, 1), 0, 0);
        queue_sweeps(140);
        wait_drained();

        // any stray result would be caught by the monitor in this window
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predicted_results.size() != 0)
            report_error($sformatf("%0d results never arrived", predicted_results.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
